>>> rtl/cpc_pkg.sv
package cpc_pkg;

    localparam int WIND_BITS = 9;
    localparam int NUM_STEPS = 24;
    localparam int STEP_BITS = 5;
    localparam logic [STEP_BITS-1:0] FIN_STEP = STEP_BITS'(NUM_STEPS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_EDGE
    } state_t;

    // multiplier operand codes
    typedef enum logic [4:0] {
        OP_EX, OP_EY, OP_NEY,
        OP_APX, OP_APY, OP_PAY,
        OP_PBX, OP_PBY,
        OP_BPX, OP_BPY,
        OP_R,
        OP_CL, OP_CH,
        OP_R2L, OP_R2H,
        OP_LL, OP_LH
    } operand_t;

    // result capture codes
    typedef enum logic [3:0] {
        SL_NONE, SL_LEN2, SL_D1, SL_D2, SL_DA, SL_DB,
        SL_R2, SL_CR, SL_CA2, SL_RL, SL_WIND
    } slot_t;

    typedef struct packed {
        operand_t    op_a;
        operand_t    op_b;
        logic [1:0]  shift;
        logic        clear;
        slot_t       slot;
    } uop_t;

    typedef struct packed {
        logic                 load;
        logic                 run;
        logic                 finish;
        logic                 sel;
        logic [STEP_BITS-1:0] step;
    } cmd_t;

    function automatic uop_t uop_rom(input logic [STEP_BITS-1:0] step);
        uop_t u;
        case (step)
            5'd0:    u = '{OP_EX,  OP_EX,  2'd0, 1'b1, SL_NONE};
            5'd1:    u = '{OP_EY,  OP_EY,  2'd0, 1'b0, SL_LEN2};
            5'd2:    u = '{OP_APX, OP_EX,  2'd0, 1'b1, SL_NONE};
            5'd3:    u = '{OP_APY, OP_EY,  2'd0, 1'b0, SL_D1};
            5'd4:    u = '{OP_EX,  OP_PBX, 2'd0, 1'b1, SL_NONE};
            5'd5:    u = '{OP_EY,  OP_PBY, 2'd0, 1'b0, SL_D2};
            5'd6:    u = '{OP_APX, OP_APX, 2'd0, 1'b1, SL_NONE};
            5'd7:    u = '{OP_APY, OP_APY, 2'd0, 1'b0, SL_DA};
            5'd8:    u = '{OP_PBX, OP_PBX, 2'd0, 1'b1, SL_NONE};
            5'd9:    u = '{OP_PBY, OP_PBY, 2'd0, 1'b0, SL_DB};
            5'd10:   u = '{OP_R,   OP_R,   2'd0, 1'b1, SL_R2};
            5'd11:   u = '{OP_EX,  OP_PBY, 2'd0, 1'b1, SL_NONE};
            5'd12:   u = '{OP_NEY, OP_PBX, 2'd0, 1'b0, SL_CR};
            5'd13:   u = '{OP_CL,  OP_CL,  2'd0, 1'b1, SL_NONE};
            5'd14:   u = '{OP_CL,  OP_CH,  2'd1, 1'b0, SL_NONE};
            5'd15:   u = '{OP_CL,  OP_CH,  2'd1, 1'b0, SL_NONE};
            5'd16:   u = '{OP_CH,  OP_CH,  2'd2, 1'b0, SL_CA2};
            5'd17:   u = '{OP_R2L, OP_LL,  2'd0, 1'b1, SL_NONE};
            5'd18:   u = '{OP_R2L, OP_LH,  2'd1, 1'b0, SL_NONE};
            5'd19:   u = '{OP_R2H, OP_LL,  2'd1, 1'b0, SL_NONE};
            5'd20:   u = '{OP_R2H, OP_LH,  2'd2, 1'b0, SL_RL};
            5'd21:   u = '{OP_APX, OP_BPY, 2'd0, 1'b1, SL_NONE};
            5'd22:   u = '{OP_PAY, OP_BPX, 2'd0, 1'b0, SL_WIND};
            default: u = '{OP_EX,  OP_EX,  2'd0, 1'b1, SL_NONE};
        endcase
        return u;
    endfunction

endpackage

>>> rtl/cpc_vertex_if.sv
interface cpc_vertex_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-2:0]        circle_radius;

    modport source (output valid, vertex_x, vertex_y, last_vertex, center_x, center_y,
                    circle_radius, input ready);
    modport sink (input valid, vertex_x, vertex_y, last_vertex, center_x, center_y,
                  circle_radius, output ready);
endinterface

>>> rtl/cpc_result_if.sv
interface cpc_result_if;
    logic valid;
    logic ready;
    logic collides;
    logic edge_touched;
    logic center_inside;

    modport source (output valid, collides, edge_touched, center_inside, input ready);
    modport sink (input valid, collides, edge_touched, center_inside, output ready);
endinterface

>>> rtl/cpc_datapath.sv
module cpc_datapath
    import cpc_pkg::*;
#(
    parameter int COORD_BITS = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_cx,
    input  logic signed [COORD_BITS-1:0] in_cy,
    input  logic [COORD_BITS-2:0]        in_r,
    output logic                         mid,
    output logic                         collides,
    output logic                         edge_touched,
    output logic                         center_inside
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;        // coordinate difference
    localparam int H   = C + 2;        // split point of the wide products
    localparam int M   = C + 3;        // multiplier operand
    localparam int DQ  = 2 * C + 2;    // squared lengths
    localparam int R2W = 2 * C - 2;
    localparam int CAW = 2 * C + 2;
    localparam int AW  = 4 * C + 8;

    logic signed [C-1:0] v_x_reg, v_y_reg, first_x_reg, first_y_reg;
    logic signed [C-1:0] prev_x_reg, prev_y_reg, cx_reg, cy_reg;
    logic [C-2:0]        r_reg;
    logic                mid_reg, hit_reg;
    logic [WIND_BITS-1:0] wind_reg;
    logic [DQ-1:0]       len2_reg, da_reg, db_reg;
    logic [R2W-1:0]      r2_reg;
    logic [CAW-1:0]      ca_reg;
    logic                d1_pos_reg, d2_pos_reg, wcr_pos_reg, wcr_neg_reg;
    logic signed [AW-1:0] acc_reg, ca2_reg, rl_reg;
    logic                out_col_reg, out_edge_reg, out_in_reg;

    logic signed [C-1:0]  a_x, a_y, b_x, b_y;
    logic signed [DW-1:0] ex, ey, ney, apx, apy, pay, pbx, pby, bpx, bpy;
    uop_t                 u;
    logic signed [M-1:0]  opa, opb;
    logic signed [2*M-1:0] prod;
    logic signed [AW-1:0] prod_ext, shifted, acc_next, acc_abs;
    logic                 hit_edge;
    logic [WIND_BITS-1:0] wind_next;

    assign a_x = cmd.sel ? v_x_reg : prev_x_reg;
    assign a_y = cmd.sel ? v_y_reg : prev_y_reg;
    assign b_x = cmd.sel ? first_x_reg : v_x_reg;
    assign b_y = cmd.sel ? first_y_reg : v_y_reg;

    assign ex  = DW'(b_x) - DW'(a_x);
    assign ey  = DW'(b_y) - DW'(a_y);
    assign ney = DW'(a_y) - DW'(b_y);
    assign apx = DW'(a_x) - DW'(cx_reg);
    assign apy = DW'(a_y) - DW'(cy_reg);
    assign pay = DW'(cy_reg) - DW'(a_y);
    assign pbx = DW'(cx_reg) - DW'(b_x);
    assign pby = DW'(cy_reg) - DW'(b_y);
    assign bpx = DW'(b_x) - DW'(cx_reg);
    assign bpy = DW'(b_y) - DW'(cy_reg);

    function automatic logic signed [M-1:0] pick(input operand_t op);
        logic signed [M-1:0] v;
        case (op)
            OP_EX:   v = M'(ex);
            OP_EY:   v = M'(ey);
            OP_NEY:  v = M'(ney);
            OP_APX:  v = M'(apx);
            OP_APY:  v = M'(apy);
            OP_PAY:  v = M'(pay);
            OP_PBX:  v = M'(pbx);
            OP_PBY:  v = M'(pby);
            OP_BPX:  v = M'(bpx);
            OP_BPY:  v = M'(bpy);
            OP_R:    v = M'({1'b0, r_reg});
            OP_CL:   v = M'({1'b0, ca_reg[H-1:0]});
            OP_CH:   v = M'({1'b0, ca_reg[CAW-1:H]});
            OP_R2L:  v = M'({1'b0, r2_reg[H-1:0]});
            OP_R2H:  v = M'({1'b0, r2_reg[R2W-1:H]});
            OP_LL:   v = M'({1'b0, len2_reg[H-1:0]});
            OP_LH:   v = M'({1'b0, len2_reg[DQ-1:H]});
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        u        = uop_rom(cmd.step);
        opa      = pick(u.op_a);
        opb      = pick(u.op_b);
        prod     = opa * opb;
        prod_ext = AW'(prod);
        case (u.shift)
            2'd1:    shifted = prod_ext <<< H;
            2'd2:    shifted = prod_ext <<< (2 * H);
            default: shifted = prod_ext;
        endcase
        acc_next = (u.clear ? '0 : acc_reg) + shifted;
        acc_abs  = acc_next[AW-1] ? -acc_next : acc_next;
    end

    // edge verdict and winding update, taken on the finish step
    always_comb
    begin
        if (len2_reg == '0 || d1_pos_reg)
            hit_edge = (da_reg <= DQ'(r2_reg));
        else if (d2_pos_reg)
            hit_edge = (db_reg <= DQ'(r2_reg));
        else
            hit_edge = (ca2_reg <= rl_reg);

        wind_next = wind_reg;
        if (!(apy > 0))
        begin
            if ((bpy > 0) && wcr_pos_reg)
                wind_next = wind_reg + 1'b1;
        end
        else
        begin
            if (!(bpy > 0) && wcr_neg_reg)
                wind_next = wind_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg      <= 1'b0;
            hit_reg      <= 1'b0;
            wind_reg     <= '0;
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            r_reg        <= '0;
        end
        else if (cmd.load)
        begin
            if (!mid_reg)
            begin
                cx_reg      <= in_cx;
                cy_reg      <= in_cy;
                r_reg       <= in_r;
                first_x_reg <= in_x;
                first_y_reg <= in_y;
                prev_x_reg  <= in_x;
                prev_y_reg  <= in_y;
                hit_reg     <= 1'b0;
                wind_reg    <= '0;
                mid_reg     <= 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            hit_reg  <= hit_reg | hit_edge;
            wind_reg <= wind_next;
            if (cmd.sel)
                mid_reg <= 1'b0;
            else
            begin
                prev_x_reg <= v_x_reg;
                prev_y_reg <= v_y_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_x_reg <= in_x;
            v_y_reg <= in_y;
        end
        if (cmd.run)
        begin
            acc_reg <= acc_next;
            case (u.slot)
                SL_LEN2: len2_reg    <= DQ'(acc_next);
                SL_D1:   d1_pos_reg  <= (acc_next > 0);
                SL_D2:   d2_pos_reg  <= (acc_next > 0);
                SL_DA:   da_reg      <= DQ'(acc_next);
                SL_DB:   db_reg      <= DQ'(acc_next);
                SL_R2:   r2_reg      <= R2W'(acc_next);
                SL_CR:   ca_reg      <= CAW'(acc_abs);
                SL_CA2:  ca2_reg     <= acc_next;
                SL_RL:   rl_reg      <= acc_next;
                SL_WIND:
                begin
                    wcr_pos_reg <= (acc_next > 0);
                    wcr_neg_reg <= acc_next[AW-1];
                end
                default: ;
            endcase
        end
        if (cmd.finish && cmd.sel)
        begin
            out_edge_reg <= hit_reg | hit_edge;
            out_in_reg   <= (wind_next != '0);
            out_col_reg  <= hit_reg | hit_edge | (wind_next != '0);
        end
    end

    assign mid           = mid_reg;
    assign collides      = out_col_reg;
    assign edge_touched  = out_edge_reg;
    assign center_inside = out_in_reg;

endmodule

>>> rtl/cpc_control.sv
module cpc_control
    import cpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_last,
    output logic in_ready,
    input  logic mid,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 sel_reg, sel_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept, at_fin, stall, fin_go;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign at_fin = (state_reg == ST_EDGE) && (step_reg == FIN_STEP);
    // closing edge cannot finish while the previous result is still unread
    assign stall  = sel_reg && out_valid_reg && !out_ready;
    assign fin_go = at_fin && !stall;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_last;
                    step_next = '0;
                    if (mid)
                    begin
                        state_next = ST_EDGE;
                        sel_next   = 1'b0;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_EDGE;
                        sel_next   = 1'b1;
                    end
                end
            end
            ST_EDGE:
            begin
                if (!at_fin)
                    step_next = step_reg + 1'b1;
                else if (!stall)
                begin
                    step_next = '0;
                    if (!sel_reg && last_reg)
                        sel_next = 1'b1;
                    else
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || (fin_go && sel_reg);
    end

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        out_valid  = out_valid_reg;
        cmd.load   = accept;
        cmd.run    = (state_reg == ST_EDGE) && (step_reg != FIN_STEP);
        cmd.finish = fin_go;
        cmd.sel    = sel_reg;
        cmd.step   = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sel_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/circle_polygon_collision.sv
// Each edge runs 23 products and one verdict on one shared multiply-accumulate unit.
// A polygon's first vertex is only stored, or runs the closing edge if it also closes the polygon;
// each later vertex runs its edge from the vertex before, and the last one also the closing edge;
// result valid the cycle after the final verdict. Input is refused during an edge; one finished
// result may wait at the output, and a closing edge holds its last cycle until it is taken.
// Asynchronous active-low reset clears the controller, the polygon state and the output valid.
module circle_polygon_collision
    import cpc_pkg::*;
#(
    parameter int COORD_BITS = 16
)(
    input  logic            clk,
    input  logic            rst_n,
    cpc_vertex_if.sink      vertex,
    cpc_result_if.source    result
);

    cmd_t cmd;
    logic mid;

    cpc_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vertex.valid),
        .in_last   (vertex.last_vertex),
        .in_ready  (vertex.ready),
        .mid       (mid),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    cpc_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .in_x          (vertex.vertex_x),
        .in_y          (vertex.vertex_y),
        .in_cx         (vertex.center_x),
        .in_cy         (vertex.center_y),
        .in_r          (vertex.circle_radius),
        .mid           (mid),
        .collides      (result.collides),
        .edge_touched  (result.edge_touched),
        .center_inside (result.center_inside)
    );

endmodule
